/* src/plq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_pkg: shared types and constants of the presence latch qualifier
// Phase and clear-cause codes, register indexes, reset values, word layout.
// ----------------------------------------------------------------------------
package plq_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int CFG_W           = 16;
	localparam int DIST_W          = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int OUT_DATA_W      = 8;

	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_CONF = 2'd1,
		PH_MON  = 2'd2,
		PH_COOL = 2'd3
	} plq_phase_t;

	typedef enum logic [1:0] {
		CAUSE_NONE    = 2'd0,
		CAUSE_ABSENCE = 2'd1,
		CAUSE_MAXTIME = 2'd2
	} plq_cause_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_DETECT    = 3'd1,
		REG_MIN_HOLD  = 3'd2,
		REG_ABSENCE   = 3'd3,
		REG_MAX_HOLD  = 3'd4,
		REG_COOLDOWN  = 3'd5
	} plq_reg_idx_t;

	localparam logic [CFG_W-1:0] RST_THRESHOLD = 16'd500;
	localparam logic [CFG_W-1:0] RST_DETECT    = 16'd5;
	localparam logic [CFG_W-1:0] RST_MIN_HOLD  = 16'd50;
	localparam logic [CFG_W-1:0] RST_ABSENCE   = 16'd15;
	localparam logic [CFG_W-1:0] RST_MAX_HOLD  = 16'd300;
	localparam logic [CFG_W-1:0] RST_COOLDOWN  = 16'd50;

	typedef struct packed {
		logic [CFG_W-1:0] distance_threshold;
		logic [CFG_W-1:0] detect_count;
		logic [CFG_W-1:0] min_hold_count;
		logic [CFG_W-1:0] absence_count;
		logic [CFG_W-1:0] max_hold_count;
		logic [CFG_W-1:0] cooldown_count;
	} plq_cfg_t;

	typedef struct packed {
		plq_phase_t phase;
		plq_cause_t clear_cause;
		logic       flag_set_pulse;
		logic       presence_flag;
	} plq_result_t;

endpackage

/* src/plq_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_cfg_regs: configuration register file
// Six 16-bit registers written by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module plq_cfg_regs
	import plq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output plq_cfg_t             cfg
);

	plq_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.distance_threshold <= RST_THRESHOLD;
			cfg_q.detect_count       <= RST_DETECT;
			cfg_q.min_hold_count     <= RST_MIN_HOLD;
			cfg_q.absence_count      <= RST_ABSENCE;
			cfg_q.max_hold_count     <= RST_MAX_HOLD;
			cfg_q.cooldown_count     <= RST_COOLDOWN;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_THRESHOLD: cfg_q.distance_threshold <= wr_data;
				REG_DETECT:    cfg_q.detect_count       <= wr_data;
				REG_MIN_HOLD:  cfg_q.min_hold_count     <= wr_data;
				REG_ABSENCE:   cfg_q.absence_count      <= wr_data;
				REG_MAX_HOLD:  cfg_q.max_hold_count     <= wr_data;
				REG_COOLDOWN:  cfg_q.cooldown_count     <= wr_data;
				default:       ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/plq_phase_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_phase_ctrl: four-phase presence controller
// Phase register, saturating run counters and the per-sample result.
// ----------------------------------------------------------------------------
module plq_phase_ctrl
	import plq_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [DIST_W-1:0] distance_mm,
	input  plq_cfg_t          cfg,
	output plq_result_t       result
);

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	plq_phase_t phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] near_q, active_q, far_q, cool_q;
	logic [COUNT_WIDTH-1:0] near_d, active_d, far_d, cool_d;
	logic [COUNT_WIDTH-1:0] near_inc, active_inc, far_inc, cool_inc;
	logic is_near, is_far;
	logic near_hit, min_hit, max_hit, far_hit, cool_hit;
	logic pulse;
	plq_cause_t cause;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + COUNT_WIDTH'(1);
	endfunction

	function automatic logic reached(input logic [COUNT_WIDTH-1:0] cnt,
	                                 input logic [CFG_W-1:0] lim);
		return CMP_W'(cnt) >= CMP_W'(lim);
	endfunction

	assign is_near = distance_mm < cfg.distance_threshold;
	assign is_far  = distance_mm > cfg.distance_threshold;

	assign near_inc   = is_near ? sat_inc(near_q) : '0;
	assign active_inc = sat_inc(active_q);
	assign far_inc    = is_far ? sat_inc(far_q) : '0;
	assign cool_inc   = sat_inc(cool_q);

	assign near_hit = reached(near_inc, cfg.detect_count);
	assign min_hit  = reached(active_inc, cfg.min_hold_count);
	assign max_hit  = reached(active_inc, cfg.max_hold_count);
	assign far_hit  = reached(far_inc, cfg.absence_count);
	assign cool_hit = reached(cool_inc, cfg.cooldown_count);

	// Next phase; max time wins over both the minimum hold and absence.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_WAIT: if (near_hit) phase_d = PH_CONF;
			PH_CONF: begin
				if (max_hit)      phase_d = PH_COOL;
				else if (min_hit) phase_d = PH_MON;
			end
			PH_MON:  if (max_hit || far_hit) phase_d = PH_COOL;
			PH_COOL: if (cool_hit) phase_d = PH_WAIT;
			default: phase_d = PH_WAIT;
		endcase
	end

	// Counter updates and the sample's pulse and clear cause.
	always_comb begin
		near_d   = near_q;
		active_d = active_q;
		far_d    = far_q;
		cool_d   = cool_q;
		pulse    = 1'b0;
		cause    = CAUSE_NONE;
		unique case (phase_q)
			PH_WAIT: begin
				if (near_hit) begin
					near_d   = '0;
					active_d = '0;
					pulse    = 1'b1;
				end else begin
					near_d = near_inc;
				end
			end
			PH_CONF: begin
				active_d = active_inc;
				if (min_hit) far_d = '0;
				if (max_hit) begin
					cool_d = '0;
					cause  = CAUSE_MAXTIME;
				end
			end
			PH_MON: begin
				active_d = active_inc;
				far_d    = far_inc;
				if (max_hit) begin
					cool_d = '0;
					cause  = CAUSE_MAXTIME;
				end else if (far_hit) begin
					cool_d = '0;
					cause  = CAUSE_ABSENCE;
				end
			end
			PH_COOL: begin
				cool_d = cool_inc;
				if (cool_hit) near_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			near_q   <= '0;
			active_q <= '0;
			far_q    <= '0;
			cool_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			near_q   <= near_d;
			active_q <= active_d;
			far_q    <= far_d;
			cool_q   <= cool_d;
		end
	end

	assign result.phase          = phase_d;
	assign result.clear_cause    = cause;
	assign result.flag_set_pulse = pulse;
	assign result.presence_flag  = (phase_d == PH_CONF) || (phase_d == PH_MON);

endmodule

/* src/presence_latch_qualifier_core.sv */
`timescale 1ns / 1ps
// Path: an input word is captured in the input register, then its result word is
//   loaded into the result register and shown on m_tdata.
// Throughput: one sample per cycle while the sink accepts results; the phase controller
//   updates its state in the same cycle that it forms the result, so samples wait only on a stalled sink.
// Reset: arst_n clears both stream stages, the phase (waiting) and all run
//   counters, and loads every configuration register with its default value.
// ----------------------------------------------------------------------------
// presence_latch_qualifier_core: range-based presence qualifier
// Input register, phase controller and result register with stream handshakes.
// ----------------------------------------------------------------------------
module presence_latch_qualifier_core
	import plq_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Sample stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DIST_W-1:0]     s_tdata,    // [15:0] distance_mm
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,    // [0] presence_flag, [1] flag_set_pulse,
	                                          // [3:2] clear_cause, [5:4] phase, [7:6] zero
	// Configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	plq_cfg_t              cfg;
	plq_result_t           result;
	logic                  in_valid_s1;
	logic [DIST_W-1:0]     dist_s1;
	logic                  out_valid_s2;
	plq_result_t           result_s2;
	logic                  advance;

	// Registers are always writable; software is to write only while the block is idle, which the block does not enforce.
	assign cfg_ready = 1'b1;

	plq_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Process the held sample when the result register is empty or draining.
	assign advance  = in_valid_s1 && (!out_valid_s2 || m_tready);
	// Take a new word whenever the input stage is empty or moves on this cycle.
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			dist_s1 <= s_tdata;
		end
	end

	plq_phase_ctrl #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_phase_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.distance_mm (dist_s1),
		.cfg         (cfg),
		.result      (result)
	);

	// Result register: load on advance, hold while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = OUT_DATA_W'(result_s2);

endmodule
